[design/stl_pkg.sv]
// Shared types, codes and keyword lookup for the source text lexer.
package stl_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int LINE_BITS_DEF   = 16;
  localparam int TYPE_W          = 6;
  localparam int LEN_W           = 16;
  localparam int LINE_W          = 16;
  localparam int ERR_W           = 2;
  localparam int PREFIX_DEPTH    = 6;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_DOT, M_NUM, M_NUMDOT, M_IDENT,
    M_STRING, M_COMMENT, M_BANG, M_EQ, M_LT, M_GT
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNEXP   = 2'd1,
    ERR_UNCLOSE = 2'd2
  } err_t;

  localparam logic [5:0] T_END = 6'd0, T_NUM = 6'd1, T_LPAREN = 6'd2, T_RPAREN = 6'd3,
    T_LBRACE = 6'd4, T_RBRACE = 6'd5, T_COMMA = 6'd6, T_DOT = 6'd7, T_MINUS = 6'd8,
    T_PLUS = 6'd9, T_STAR = 6'd10, T_DIV = 6'd11, T_SEMI = 6'd12, T_NE = 6'd13,
    T_NOT = 6'd14, T_EQEQ = 6'd15, T_EQ = 6'd16, T_SHL = 6'd17, T_LE = 6'd18,
    T_LT = 6'd19, T_SHR = 6'd20, T_GE = 6'd21, T_GT = 6'd22, T_STR = 6'd23,
    T_IDENT = 6'd40, T_ERROR = 6'd41;

  // Keyword token codes.
  localparam logic [5:0] T_AND = 6'd24, T_CLASS = 6'd25, T_ELSE = 6'd26, T_IF = 6'd27,
    T_NONE = 6'd28, T_OR = 6'd29, T_LET = 6'd30, T_PRINT = 6'd31, T_RETURN = 6'd32,
    T_SUPER = 6'd33, T_WHILE = 6'd34, T_FALSE = 6'd35, T_FOR = 6'd36, T_FUNC = 6'd37,
    T_THIS = 6'd38, T_TRUE = 6'd39;

  // One emitted token before line stamping.
  typedef struct packed {
    logic [TYPE_W-1:0] ttype;
    logic [31:0]       len;
    logic [ERR_W-1:0]  err;
  } tok_t;

  typedef logic [7:0] prefix_t [PREFIX_DEPTH];

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic name_byte(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  // Whole-text keyword match on the stored prefix.
  function automatic logic [5:0] classify(input prefix_t p, input logic [31:0] len);
    logic [47:0] w;
    logic [5:0] r;
    w = {p[0], p[1], p[2], p[3], p[4], p[5]};
    r = T_IDENT;
    case (len)
      32'd2: begin
        if (w[47:32] == "if") r = T_IF;
        else if (w[47:32] == "or") r = T_OR;
      end
      32'd3: begin
        if (w[47:24] == "and") r = T_AND;
        else if (w[47:24] == "let") r = T_LET;
        else if (w[47:24] == "for") r = T_FOR;
      end
      32'd4: begin
        if (w[47:16] == "else") r = T_ELSE;
        else if (w[47:16] == "none") r = T_NONE;
        else if (w[47:16] == "func") r = T_FUNC;
        else if (w[47:16] == "this") r = T_THIS;
        else if (w[47:16] == "true") r = T_TRUE;
      end
      32'd5: begin
        if (w[47:8] == "class") r = T_CLASS;
        else if (w[47:8] == "print") r = T_PRINT;
        else if (w[47:8] == "super") r = T_SUPER;
        else if (w[47:8] == "while") r = T_WHILE;
        else if (w[47:8] == "false") r = T_FALSE;
      end
      32'd6: begin
        if (w == "return") r = T_RETURN;
      end
      default: r = T_IDENT;
    endcase
    return r;
  endfunction

endpackage

[design/stl_out_queue.sv]
// Result queue that spreads up to three tokens of one character over output cycles.
module stl_out_queue #(
  parameter int DEPTH = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push_valid,
  input  logic [1:0]                push_count,
  input  logic [stl_pkg::TYPE_W+stl_pkg::LEN_W+stl_pkg::LINE_W+stl_pkg::ERR_W+1-1:0]
                                    push_word [3],
  output logic                      has_room,
  output logic                      pop_valid,
  input  logic                      pop_stall,
  output logic [stl_pkg::TYPE_W+stl_pkg::LEN_W+stl_pkg::LINE_W+stl_pkg::ERR_W+1-1:0]
                                    pop_word
);
  import stl_pkg::*;
  localparam int WW = TYPE_W + LEN_W + LINE_W + ERR_W + 1;
  localparam int AW = $clog2(DEPTH);

  logic [WW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [AW:0]   fill, fill_next;
  logic          pop;
  logic [AW:0]   pushed;

  assign pop       = pop_valid && !pop_stall;
  assign pop_valid = fill != '0;
  assign pop_word  = mem[rd_ptr];
  assign pushed    = push_valid ? (AW+1)'(push_count) : '0;
  // Hold room for a full three-token burst.
  assign has_room  = fill <= (AW+1)'(DEPTH - 3);
  assign fill_next = fill + pushed - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      fill   <= fill_next;
      wr_ptr <= wr_ptr + AW'(pushed);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (push_valid && i < push_count) mem[wr_ptr + AW'(i)] <= push_word[i];
    end
  end
endmodule

[design/source_text_lexer_top.sv]
// Top level of the streaming source text lexer.
// Usage:
//   Input channel: one source byte per word on char_code with in_valid/in_stall.
//   Code 0 ends the text: any pending token is flushed, END is emitted and the
//   scanner returns to its reset state, ready for the next text.
//   Output channel: one token per word (token_type, token_length, line_number,
//   error_kind, last_of_run) with out_valid/out_stall. last_of_run marks the
//   final token caused by one input byte; a byte may cause zero to three tokens.
// Throughput:
//   One byte is scanned per cycle, while in_stall is low, in a single registered
//   pass; its tokens are written to an eight-word result queue and leave it in
//   order, one token per cycle while out_stall is low. Sustained rate is one byte
//   per cycle while the receiver drains tokens as fast as they are made.
// Stall:
//   The queue keeps room for a three-token burst; when it fills, in_stall rises
//   and bytes wait upstream. Nothing is dropped.
// Reset:
//   rst (synchronous, high) empties the queue and sets mode idle, line 1.
module source_text_lexer_top #(
  parameter int LENGTH_BITS = stl_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    char_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stl_pkg::TYPE_W-1:0]    token_type,
  output logic [stl_pkg::LEN_W-1:0]     token_length,
  output logic [stl_pkg::LINE_W-1:0]    line_number,
  output logic [stl_pkg::ERR_W-1:0]     error_kind,
  output logic                          last_of_run
);
  import stl_pkg::*;
  localparam int WW = TYPE_W + LEN_W + LINE_W + ERR_W + 1;
  localparam logic [31:0] LEN_MAX  = 32'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [31:0] LINE_MAX = 32'((64'd1 << LINE_BITS) - 64'd1);

  // Scanner state.
  mode_t       mode, mode_next;
  logic [31:0] lex_len, lex_len_next;
  logic [31:0] line_cnt, line_cnt_next;
  prefix_t     prefix;
  logic        frac, frac_next;
  logic        pfx_we;
  logic [2:0]  pfx_idx;

  logic        accept;
  logic [7:0]  c;
  tok_t        toks [3];
  logic [31:0] tok_line [3];
  logic [1:0]  ntok;
  logic        room;
  logic [WW-1:0] words [3];
  logic [WW-1:0] head;

  assign accept = in_valid && !in_stall;
  assign in_stall = !room;
  assign c = char_code;

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic [31:0] n,
                                          input logic [31:0] mx);
    logic [32:0] s;
    s = {1'b0, v} + {1'b0, n};
    return (s > {1'b0, mx}) ? mx : s[31:0];
  endfunction

  always_comb begin
    logic absorbed;
    mode_next     = mode;
    lex_len_next  = lex_len;
    line_cnt_next = line_cnt;
    frac_next     = frac;
    pfx_we        = 1'b0;
    pfx_idx       = '0;
    ntok          = '0;
    absorbed      = 1'b0;
    for (int i = 0; i < 3; i++) begin
      toks[i] = '{ttype: T_END, len: '0, err: ERR_NONE};
      tok_line[i] = line_cnt;
    end

    // Offer the byte to the pending token.
    if (mode != M_IDLE) begin
      mode_next = M_IDLE;
      case (mode)
        M_SLASH: begin
          if (c == "/") begin
            mode_next = M_COMMENT; absorbed = 1'b1;
          end else begin
            toks[0] = '{T_DIV, 32'd1, ERR_NONE}; ntok = 2'd1;
          end
        end
        M_DOT: begin
          if (digit_byte(c)) begin
            mode_next = M_NUM; lex_len_next = 32'd2; frac_next = 1'b0; absorbed = 1'b1;
          end else begin
            toks[0] = '{T_DOT, 32'd1, ERR_NONE}; ntok = 2'd1;
          end
        end
        M_NUM: begin
          if (digit_byte(c)) begin
            mode_next = M_NUM; lex_len_next = sat_inc(lex_len, 32'd1, LEN_MAX);
            absorbed = 1'b1;
          end else if (c == "." && !frac) begin
            mode_next = M_NUMDOT; absorbed = 1'b1;
          end else begin
            toks[0] = '{T_NUM, lex_len, ERR_NONE}; ntok = 2'd1;
          end
        end
        M_NUMDOT: begin
          if (digit_byte(c)) begin
            mode_next = M_NUM; frac_next = 1'b1;
            lex_len_next = sat_inc(lex_len, 32'd2, LEN_MAX); absorbed = 1'b1;
          end else begin
            toks[0] = '{T_NUM, lex_len, ERR_NONE};
            toks[1] = '{T_DOT, 32'd1, ERR_NONE}; ntok = 2'd2;
          end
        end
        M_IDENT: begin
          if (name_byte(c) || digit_byte(c)) begin
            mode_next = M_IDENT;
            if (lex_len < 32'(PREFIX_DEPTH)) begin
              pfx_we = 1'b1; pfx_idx = lex_len[2:0];
            end
            lex_len_next = sat_inc(lex_len, 32'd1, LEN_MAX); absorbed = 1'b1;
          end else begin
            toks[0] = '{classify(prefix, lex_len), lex_len, ERR_NONE}; ntok = 2'd1;
          end
        end
        M_STRING: begin
          if (c == 8'd0) begin
            toks[0] = '{T_ERROR, lex_len, ERR_UNCLOSE}; ntok = 2'd1;
          end else begin
            lex_len_next = sat_inc(lex_len, 32'd1, LEN_MAX); absorbed = 1'b1;
            if (c == 8'h22) begin
              toks[0] = '{T_STR, lex_len_next, ERR_NONE}; ntok = 2'd1;
            end else begin
              if (c == 8'h0a) line_cnt_next = sat_inc(line_cnt, 32'd1, LINE_MAX);
              mode_next = M_STRING;
            end
          end
        end
        M_COMMENT: begin
          if (c != 8'h0a && c != 8'd0) begin
            mode_next = M_COMMENT; absorbed = 1'b1;
          end
        end
        M_BANG: begin
          if (c == "=") begin
            toks[0] = '{T_NE, 32'd2, ERR_NONE}; absorbed = 1'b1;
          end else toks[0] = '{T_NOT, 32'd1, ERR_NONE};
          ntok = 2'd1;
        end
        M_EQ: begin
          if (c == "=") begin
            toks[0] = '{T_EQEQ, 32'd2, ERR_NONE}; absorbed = 1'b1;
          end else toks[0] = '{T_EQ, 32'd1, ERR_NONE};
          ntok = 2'd1;
        end
        M_LT: begin
          if (c == "<") begin
            toks[0] = '{T_SHL, 32'd2, ERR_NONE}; absorbed = 1'b1;
          end else if (c == "=") begin
            toks[0] = '{T_LE, 32'd2, ERR_NONE}; absorbed = 1'b1;
          end else toks[0] = '{T_LT, 32'd1, ERR_NONE};
          ntok = 2'd1;
        end
        M_GT: begin
          if (c == ">") begin
            toks[0] = '{T_SHR, 32'd2, ERR_NONE}; absorbed = 1'b1;
          end else if (c == "=") begin
            toks[0] = '{T_GE, 32'd2, ERR_NONE}; absorbed = 1'b1;
          end else toks[0] = '{T_GT, 32'd1, ERR_NONE};
          ntok = 2'd1;
        end
        default: mode_next = M_IDLE;
      endcase
    end
    for (int i = 0; i < 3; i++) tok_line[i] = line_cnt_next;

    // Start a fresh token when the byte was not absorbed.
    if (!absorbed) begin
      case (c) inside
        8'd0: begin
          toks[ntok] = '{T_END, 32'd0, ERR_NONE}; tok_line[ntok] = line_cnt_next;
          ntok = ntok + 2'd1;
          mode_next = M_IDLE; lex_len_next = '0; line_cnt_next = 32'd1; frac_next = 1'b0;
        end
        8'h20, 8'h0d, 8'h09: ;
        8'h0a: line_cnt_next = sat_inc(line_cnt_next, 32'd1, LINE_MAX);
        "/": begin mode_next = M_SLASH;  lex_len_next = 32'd1; end
        ".": begin mode_next = M_DOT;    lex_len_next = 32'd1; end
        8'h22: begin mode_next = M_STRING; lex_len_next = 32'd1; end
        "!": begin mode_next = M_BANG;   lex_len_next = 32'd1; end
        "=": begin mode_next = M_EQ;     lex_len_next = 32'd1; end
        "<": begin mode_next = M_LT;     lex_len_next = 32'd1; end
        ">": begin mode_next = M_GT;     lex_len_next = 32'd1; end
        "(", ")", "{", "}", ",", "-", "+", "*", ";": begin
          case (c)
            "(": toks[ntok].ttype = T_LPAREN;
            ")": toks[ntok].ttype = T_RPAREN;
            "{": toks[ntok].ttype = T_LBRACE;
            "}": toks[ntok].ttype = T_RBRACE;
            ",": toks[ntok].ttype = T_COMMA;
            "-": toks[ntok].ttype = T_MINUS;
            "+": toks[ntok].ttype = T_PLUS;
            "*": toks[ntok].ttype = T_STAR;
            default: toks[ntok].ttype = T_SEMI;
          endcase
          toks[ntok].len = 32'd1; toks[ntok].err = ERR_NONE;
          ntok = ntok + 2'd1;
        end
        default: begin
          if (digit_byte(c)) begin
            mode_next = M_NUM; lex_len_next = 32'd1; frac_next = 1'b0;
          end else if (name_byte(c)) begin
            mode_next = M_IDENT; lex_len_next = 32'd1; pfx_we = 1'b1; pfx_idx = 3'd0;
          end else begin
            toks[ntok] = '{T_ERROR, 32'd1, ERR_UNEXP}; ntok = ntok + 2'd1;
          end
        end
      endcase
    end
  end

  // Build queue words; mark the last token of this byte.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      words[i] = {toks[i].ttype, toks[i].len[LEN_W-1:0], tok_line[i][LINE_W-1:0],
                  toks[i].err, (2'(i) == ntok - 2'd1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      lex_len  <= '0;
      line_cnt <= 32'd1;
      frac     <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      lex_len  <= lex_len_next;
      line_cnt <= line_cnt_next;
      frac     <= frac_next;
    end
  end

  // Identifier prefix store: written only, no reset.
  always_ff @(posedge clk) begin
    if (accept && pfx_we) prefix[pfx_idx] <= c;
  end

  stl_out_queue #(.DEPTH(8)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (accept && ntok != 2'd0),
    .push_count (ntok),
    .push_word  (words),
    .has_room   (room),
    .pop_valid  (out_valid),
    .pop_stall  (out_stall),
    .pop_word   (head)
  );

  assign {token_type, token_length, line_number, error_kind, last_of_run} = head;
endmodule

[design/stl_checker.sv]
// Port-level checks for the source text lexer, bound to the top level.
module stl_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] token_type,
  input logic [15:0] token_length,
  input logic [15:0] line_number,
  input logic [1:0] error_kind,
  input logic       last_of_run
);
  import stl_pkg::*;

  // A stalled token's type and length hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_type) && $stable(token_length))
    else $error("stalled token changed");

  // END always closes a run and has zero length.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_type == T_END |-> last_of_run && token_length == 16'd0)
    else $error("END not last or nonzero length");

  // Line numbers never read zero.
  a_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != 16'd0)
    else $error("line number zero");

  // Error kind agrees with the token type.
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((error_kind != ERR_NONE) == (token_type == T_ERROR)))
    else $error("error kind mismatch");
endmodule

bind source_text_lexer_top stl_checker u_stl_checker (.*);
